// ===== rtl/message_receive_matcher_top_defines.svh =====
// Assertion macros for the message receive matcher.
// Each macro checks a property on the rising clock edge while reset is released.
`ifndef MESSAGE_RECEIVE_MATCHER_TOP_DEFINES_SVH
`define MESSAGE_RECEIVE_MATCHER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define MRM_ASSERT_NOW(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);
`define MRM_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define MRM_ASSERT_NOW(name, cond, msg)
`define MRM_ASSERT_IMPLY(name, ante, cons, msg)
`endif

`endif

// ===== rtl/mrm_pkg.sv =====
package mrm_pkg;

    typedef enum logic [1:0] {
        ST_MATCHED  = 2'd0,
        ST_QUEUED   = 2'd1,
        ST_SIZE_ERR = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_POST   = 1'b1;

    typedef struct packed {
        logic [15:0] context_id;
        logic [30:0] msg_tag;
        logic [15:0] source_rank;
        logic [31:0] byte_size;
        logic [15:0] entry_handle;
    } entry_t;

    typedef struct packed {
        logic        active;
        logic        found;
        logic        err;
        logic [31:0] byte_size;
        logic [15:0] entry_handle;
    } carry_t;

    typedef struct packed {
        logic start;
        logic wr;
        logic shift;
    } cell_ctl_t;

endpackage

// ===== rtl/mrm_cell.sv =====
module mrm_cell #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned IDX   = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mrm_pkg::cell_ctl_t            ctl,
    input  logic [$clog2(DEPTH)-1:0]      wr_idx,
    input  logic [$clog2(DEPTH+1)-1:0]    fill,
    input  mrm_pkg::entry_t               key,
    input  mrm_pkg::carry_t               carry_in,
    input  mrm_pkg::entry_t               next_entry,
    output mrm_pkg::carry_t               carry_out,
    output mrm_pkg::entry_t               entry
);

    localparam int unsigned FW = $clog2(DEPTH + 1);
    localparam int unsigned IW = $clog2(DEPTH);
    localparam logic [FW-1:0] IDX_F = FW'(IDX);
    localparam logic [IW-1:0] IDX_I = IW'(IDX);

    mrm_pkg::entry_t entry_reg;
    mrm_pkg::carry_t carry_reg;
    mrm_pkg::carry_t carry_next;
    logic            del_reg;
    logic            del_next;
    logic            live;
    logic            hit;

    assign live = (IDX_F < fill);
    assign hit  = carry_in.active && !carry_in.found && live
                  && (entry_reg.context_id == key.context_id)
                  && (entry_reg.msg_tag == key.msg_tag)
                  && (entry_reg.source_rank == key.source_rank);

    always_comb
    begin
        carry_next.active       = carry_in.active;
        carry_next.found        = carry_in.found || hit;
        carry_next.err          = carry_in.err;
        carry_next.byte_size    = carry_in.byte_size;
        carry_next.entry_handle = carry_in.entry_handle;
        if (hit)
        begin
            carry_next.err          = (entry_reg.byte_size > key.byte_size);
            carry_next.byte_size    = entry_reg.byte_size;
            carry_next.entry_handle = entry_reg.entry_handle;
        end
        del_next = del_reg;
        if (carry_in.active)
        begin
            del_next = carry_in.found || hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= '0;
            del_reg   <= 1'b0;
        end
        else
        begin
            carry_reg <= carry_next;
            del_reg   <= del_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr && (wr_idx == IDX_I))
        begin
            entry_reg <= key;
        end
        else if (ctl.shift && del_reg)
        begin
            entry_reg <= next_entry;
        end
    end

    assign carry_out = carry_reg;
    assign entry     = entry_reg;

endmodule

// ===== rtl/mrm_ctrl.sv =====
module mrm_ctrl #(
    parameter int unsigned UNEXP_DEPTH  = 32,
    parameter int unsigned POSTED_DEPTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               cmd,
    input  logic [15:0]                        context_id,
    input  logic [30:0]                        msg_tag,
    input  logic [15:0]                        source_rank,
    input  logic [31:0]                        byte_size,
    input  logic [15:0]                        entry_handle,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         status,
    output logic [15:0]                        matched_handle,
    output logic [31:0]                        matched_size,
    output logic [5:0]                         posted_count,
    output logic [5:0]                         unexpected_count,
    output mrm_pkg::cell_ctl_t                 ctl,
    output logic [$clog2(UNEXP_DEPTH)-1:0]     wr_idx,
    output logic [$clog2(UNEXP_DEPTH+1)-1:0]   unexp_fill,
    output mrm_pkg::entry_t                    key,
    input  mrm_pkg::carry_t                    tail
);

    localparam int unsigned UFW = $clog2(UNEXP_DEPTH + 1);
    localparam int unsigned UIW = $clog2(UNEXP_DEPTH);
    localparam int unsigned PFW = $clog2(POSTED_DEPTH + 1);
    localparam logic [UFW-1:0] UNEXP_MAX  = UFW'(UNEXP_DEPTH);
    localparam logic [PFW-1:0] POSTED_MAX = PFW'(POSTED_DEPTH);

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        OUT
    } state_t;

    state_t             state_reg, state_next;
    mrm_pkg::entry_t    key_reg, key_next;
    mrm_pkg::cell_ctl_t ctl_reg, ctl_next;
    logic [UIW-1:0]     wr_idx_reg, wr_idx_next;
    logic [UFW-1:0]     ufill_reg, ufill_next;
    logic [PFW-1:0]     pfill_reg, pfill_next;
    mrm_pkg::status_t   status_reg, status_next;
    logic [15:0]        handle_reg, handle_next;
    logic [31:0]        size_reg, size_next;

    always_comb
    begin
        state_next  = state_reg;
        key_next    = key_reg;
        ctl_next    = '0;
        wr_idx_next = wr_idx_reg;
        ufill_next  = ufill_reg;
        pfill_next  = pfill_reg;
        status_next = status_reg;
        handle_next = handle_reg;
        size_next   = size_reg;
        case (state_reg)
            IDLE:
            begin
                if (in_valid)
                begin
                    key_next.context_id   = context_id;
                    key_next.msg_tag      = msg_tag;
                    key_next.source_rank  = source_rank;
                    key_next.byte_size    = byte_size;
                    key_next.entry_handle = entry_handle;
                    handle_next           = '0;
                    size_next             = '0;
                    if (cmd == mrm_pkg::CMD_APPEND)
                    begin
                        state_next = OUT;
                        if (ufill_reg == UNEXP_MAX)
                        begin
                            status_next = mrm_pkg::ST_FULL;
                        end
                        else
                        begin
                            status_next  = mrm_pkg::ST_QUEUED;
                            ctl_next.wr  = 1'b1;
                            wr_idx_next  = ufill_reg[UIW-1:0];
                            ufill_next   = ufill_reg + UFW'(1);
                        end
                    end
                    else
                    begin
                        ctl_next.start = 1'b1;
                        state_next     = SCAN;
                    end
                end
            end
            SCAN:
            begin
                if (tail.active)
                begin
                    state_next = OUT;
                    if (tail.found)
                    begin
                        if (tail.err)
                        begin
                            status_next = mrm_pkg::ST_SIZE_ERR;
                        end
                        else
                        begin
                            status_next    = mrm_pkg::ST_MATCHED;
                            handle_next    = tail.entry_handle;
                            size_next      = tail.byte_size;
                            ctl_next.shift = 1'b1;
                            ufill_next     = ufill_reg - UFW'(1);
                        end
                    end
                    else if (pfill_reg == POSTED_MAX)
                    begin
                        status_next = mrm_pkg::ST_FULL;
                    end
                    else
                    begin
                        status_next = mrm_pkg::ST_QUEUED;
                        pfill_next  = pfill_reg + PFW'(1);
                    end
                end
            end
            OUT:
            begin
                if (!out_stall)
                begin
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= IDLE;
            key_reg    <= '0;
            ctl_reg    <= '0;
            wr_idx_reg <= '0;
            ufill_reg  <= '0;
            pfill_reg  <= '0;
            status_reg <= mrm_pkg::ST_QUEUED;
            handle_reg <= '0;
            size_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            key_reg    <= key_next;
            ctl_reg    <= ctl_next;
            wr_idx_reg <= wr_idx_next;
            ufill_reg  <= ufill_next;
            pfill_reg  <= pfill_next;
            status_reg <= status_next;
            handle_reg <= handle_next;
            size_reg   <= size_next;
        end
    end

    assign in_stall         = (state_reg != IDLE);
    assign out_valid        = (state_reg == OUT);
    assign status           = status_reg;
    assign matched_handle   = handle_reg;
    assign matched_size     = size_reg;
    assign posted_count     = 6'(pfill_reg);
    assign unexpected_count = 6'(ufill_reg);
    assign ctl              = ctl_reg;
    assign wr_idx           = wr_idx_reg;
    assign unexp_fill       = ufill_reg;
    assign key              = key_reg;

endmodule

// ===== rtl/message_receive_matcher_top.sv =====
// Two-queue message matcher. An append item (cmd 0) lands at the tail of the unexpected
// queue if it is not full and is answered in the cycle after it is accepted. A post item
// (cmd 1) sends a search token down a row of UNEXP_DEPTH cells, one cell per cycle, oldest
// entry first; the first cell that matches context, tag and source captures its size and
// handle into the token, and marks itself and every younger cell for a one-cycle shift that
// closes the gap if the entry fits. A post is answered once the token leaves the row.
// One item is in flight at a time; the next is taken once the result has been taken.
// The posted queue is tracked by its fill count. Count outputs carry the low six bits.
`include "message_receive_matcher_top_defines.svh"

module message_receive_matcher_top #(
    parameter int unsigned UNEXP_DEPTH  = 32,
    parameter int unsigned POSTED_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [15:0] context_id,
    input  logic [30:0] msg_tag,
    input  logic [15:0] source_rank,
    input  logic [31:0] byte_size,
    input  logic [15:0] entry_handle,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [15:0] matched_handle,
    output logic [31:0] matched_size,
    output logic [5:0]  posted_count,
    output logic [5:0]  unexpected_count
);

    localparam int unsigned UFW = $clog2(UNEXP_DEPTH + 1);
    localparam int unsigned UIW = $clog2(UNEXP_DEPTH);

    mrm_pkg::cell_ctl_t ctl;
    logic [UIW-1:0]     wr_idx;
    logic [UFW-1:0]     unexp_fill;
    mrm_pkg::entry_t    key;
    mrm_pkg::carry_t    carry [UNEXP_DEPTH+1];
    mrm_pkg::entry_t    entries [UNEXP_DEPTH+1];

    mrm_ctrl #(
        .UNEXP_DEPTH  (UNEXP_DEPTH),
        .POSTED_DEPTH (POSTED_DEPTH)
    ) u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .cmd              (cmd),
        .context_id       (context_id),
        .msg_tag          (msg_tag),
        .source_rank      (source_rank),
        .byte_size        (byte_size),
        .entry_handle     (entry_handle),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .matched_handle   (matched_handle),
        .matched_size     (matched_size),
        .posted_count     (posted_count),
        .unexpected_count (unexpected_count),
        .ctl              (ctl),
        .wr_idx           (wr_idx),
        .unexp_fill       (unexp_fill),
        .key              (key),
        .tail             (carry[UNEXP_DEPTH])
    );

    always_comb
    begin
        carry[0]        = '0;
        carry[0].active = ctl.start;
    end

    assign entries[UNEXP_DEPTH] = entries[UNEXP_DEPTH-1];

    for (genvar i = 0; i < UNEXP_DEPTH; i++)
    begin : g_cell
        mrm_cell #(
            .DEPTH (UNEXP_DEPTH),
            .IDX   (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .wr_idx     (wr_idx),
            .fill       (unexp_fill),
            .key        (key),
            .carry_in   (carry[i]),
            .next_entry (entries[i+1]),
            .carry_out  (carry[i+1]),
            .entry      (entries[i])
        );
    end

    `MRM_ASSERT_NOW(a_fill_bound, unexp_fill <= UFW'(UNEXP_DEPTH), "unexpected fill above depth")
    `MRM_ASSERT_IMPLY(a_tail_in_scan, carry[UNEXP_DEPTH].active, in_stall && !out_valid, "token at tail outside a search")
    `MRM_ASSERT_IMPLY(a_match_pops, $rose(out_valid) && status == mrm_pkg::ST_MATCHED, unexp_fill == $past(unexp_fill) - UFW'(1), "match did not remove an entry")
    `MRM_ASSERT_IMPLY(a_zero_unmatched, out_valid && status != mrm_pkg::ST_MATCHED, matched_handle == 16'd0 && matched_size == 32'd0, "unmatched result carries data")

endmodule
